FILE: hdl/tss_pkg.sv
// Shared types and constants for the triangle scanline span pipeline.
// Used by tss_div and triangle_scanline_span.
package tss_pkg;
	localparam int COORD_BITS_DEF = 12;
	localparam int OUT_BITS = 12;
endpackage

FILE: hdl/triangle_scanline_span.sv
// Top level: triangle scanline span pipeline.
// Depends on tss_pkg and tss_div.
// One item enters per cycle while busy is low (busy is always low here); done rises
// once its start transfer has passed the sort and product registers and two chained
// bit-per-stage dividers (split x, then edge x). The receiver cannot stall, so
// results leave on done in the same order as starts with no backpressure.
module triangle_scanline_span #(
	parameter int COORD_BITS = tss_pkg::COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [COORD_BITS-1:0] vertex_a_x,
	input  logic [COORD_BITS-1:0] vertex_a_y,
	input  logic [COORD_BITS-1:0] vertex_b_x,
	input  logic [COORD_BITS-1:0] vertex_b_y,
	input  logic [COORD_BITS-1:0] vertex_c_x,
	input  logic [COORD_BITS-1:0] vertex_c_y,
	input  logic [COORD_BITS-1:0] scan_y,
	output logic                  done,
	output logic                  span_valid,
	output logic [tss_pkg::OUT_BITS-1:0] span_start,
	output logic [tss_pkg::OUT_BITS-1:0] span_end
);
	import tss_pkg::*;
	localparam int C = COORD_BITS;
	localparam int SW = C + 1;
	localparam int NW = 2 * C + 1;
	localparam int L1 = NW;
	// tag1: x1,y1,x2,y2,x3,y3,y,inrange
	localparam int T1 = 7 * C + 1;
	// tag2: xs, xe, inrange
	localparam int T2 = 2 * C + 1;

	assign busy = 1'b0;

	// stage 1: sort
	logic [C-1:0] x1, y1, x2, y2, x3, y3, tx, ty;
	logic         v_s1;
	logic [C-1:0] x1_s1, y1_s1, x2_s1, y2_s1, x3_s1, y3_s1, sy_s1;

	always_comb begin
		x1 = vertex_a_x; y1 = vertex_a_y;
		x2 = vertex_b_x; y2 = vertex_b_y;
		x3 = vertex_c_x; y3 = vertex_c_y;
		tx = '0; ty = '0;
		if (y2 < y1) begin
			tx = x1; ty = y1; x1 = x2; y1 = y2; x2 = tx; y2 = ty;
		end
		if (y3 < y2) begin
			tx = x2; ty = y2; x2 = x3; y2 = y3; x3 = tx; y3 = ty;
		end
		if (y2 < y1) begin
			tx = x1; ty = y1; x1 = x2; y1 = y2; x2 = tx; y2 = ty;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start;
	end
	always_ff @(posedge clk) begin
		x1_s1 <= x1; y1_s1 <= y1; x2_s1 <= x2; y2_s1 <= y2;
		x3_s1 <= x3; y3_s1 <= y3; sy_s1 <= scan_y;
	end

	// stage 2: split-vertex product
	logic               v_s2;
	logic signed [NW-1:0] sp_s2;
	logic signed [SW-1:0] sd_s2;
	logic [T1-1:0]      tg_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		sp_s2 <= NW'($signed({1'b0, y2_s1}) - $signed({1'b0, y1_s1}))
			* NW'($signed({1'b0, x3_s1}) - $signed({1'b0, x1_s1}));
		sd_s2 <= $signed({1'b0, y3_s1}) - $signed({1'b0, y1_s1});
		tg_s2 <= {x1_s1, y1_s1, x2_s1, y2_s1, x3_s1, y3_s1, sy_s1,
			!(sy_s1 < y1_s1 || sy_s1 > y3_s1)};
	end

	// divider 1: split x
	logic signed [NW-1:0] q1;
	logic [T1-1:0]        tg1;
	logic [L1-1:0]        vp1_q;
	tss_div #(.NW(NW), .DW(SW), .TW(T1)) u_div_split (
		.clk(clk), .en(1'b1), .num(sp_s2), .den(sd_s2),
		.tag_in(tg_s2), .quo(q1), .tag_out(tg1)
	);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vp1_q <= '0;
		else vp1_q <= {vp1_q[L1-2:0], v_s2};
	end

	// stage 3: edge selection, per-edge products
	logic [C-1:0] a1x, a1y, a2x, a2y, a3x, a3y, ay, x4;
	logic         ain;
	logic [C-1:0] ea_x, ea_y, eb_x, eb_y, fa_x, fa_y, fb_x, fb_y;
	always_comb begin
		{a1x, a1y, a2x, a2y, a3x, a3y, ay, ain} = tg1;
		x4 = C'($signed({1'b0, a1x}) + q1);
		if (a2y == a3y) begin
			ea_x = a1x; ea_y = a1y; eb_x = a2x; eb_y = a2y;
			fa_x = a1x; fa_y = a1y; fb_x = a3x; fb_y = a3y;
		end else if (a1y == a2y) begin
			ea_x = a1x; ea_y = a1y; eb_x = a3x; eb_y = a3y;
			fa_x = a2x; fa_y = a2y; fb_x = a3x; fb_y = a3y;
		end else if (ay <= a2y) begin
			ea_x = a1x; ea_y = a1y; eb_x = a2x; eb_y = a2y;
			fa_x = a1x; fa_y = a1y; fb_x = x4;  fb_y = a2y;
		end else begin
			ea_x = a2x; ea_y = a2y; eb_x = a3x; eb_y = a3y;
			fa_x = x4;  fa_y = a2y; fb_x = a3x; fb_y = a3y;
		end
	end

	logic                 v_s3;
	logic signed [NW-1:0] pa_s3, pb_s3;
	logic signed [SW-1:0] da_s3, db_s3;
	logic [T2-1:0]        tg_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= vp1_q[L1-1];
	end
	always_ff @(posedge clk) begin
		pa_s3 <= NW'($signed({1'b0, ay}) - $signed({1'b0, ea_y}))
			* NW'($signed({1'b0, eb_x}) - $signed({1'b0, ea_x}));
		pb_s3 <= NW'($signed({1'b0, ay}) - $signed({1'b0, fa_y}))
			* NW'($signed({1'b0, fb_x}) - $signed({1'b0, fa_x}));
		da_s3 <= $signed({1'b0, eb_y}) - $signed({1'b0, ea_y});
		db_s3 <= $signed({1'b0, fb_y}) - $signed({1'b0, fa_y});
		tg_s3 <= {ea_x, fa_x, ain};
	end

	// dividers 2: both edges
	logic signed [NW-1:0] qa, qb;
	logic [C:0]           tga;
	logic [C-1:0]         unused_tag;
	logic [L1-1:0]        vp2_q;
	tss_div #(.NW(NW), .DW(SW), .TW(C + 1)) u_div_a (
		.clk(clk), .en(1'b1), .num(pa_s3), .den(da_s3),
		.tag_in({tg_s3[T2-1 -: C], tg_s3[0]}), .quo(qa), .tag_out(tga)
	);
	tss_div #(.NW(NW), .DW(SW), .TW(C)) u_div_b (
		.clk(clk), .en(1'b1), .num(pb_s3), .den(db_s3),
		.tag_in(tg_s3[C:1]), .quo(qb), .tag_out(unused_tag)
	);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vp2_q <= '0;
		else vp2_q <= {vp2_q[L1-2:0], v_s3};
	end

	// output register
	logic [NW-1:0] xs, xe;
	always_comb begin
		xs = NW'($signed({1'b0, tga[C:1]}) + qa);
		xe = NW'($signed({1'b0, unused_tag}) + qb);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
			span_valid <= 1'b0;
			span_start <= '0;
			span_end <= '0;
		end else begin
			done <= vp2_q[L1-1];
			span_valid <= tga[0];
			span_start <= tga[0] ? OUT_BITS'(xs) : '0;
			span_end <= tga[0] ? OUT_BITS'(xe) : '0;
		end
	end
endmodule

FILE: hdl/tss_div.sv
// Pipelined signed divider, restoring, one quotient bit per stage.
// Quotient truncates toward zero. Zero divisor gives zero. Uses tss_pkg.
module tss_div #(
	parameter int NW = 25,
	parameter int DW = 13,
	parameter int TW = 12
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [NW-1:0] num,
	input  logic signed [DW-1:0] den,
	input  logic [TW-1:0]        tag_in,
	output logic signed [NW-1:0] quo,
	output logic [TW-1:0]        tag_out
);
	import tss_pkg::*;
	localparam int M = NW;
	logic [M-1:0]  n_q [1:M-1];
	logic [DW-1:0] r_q [1:M-1];
	logic [M-1:0]  q_q [1:M];
	logic [DW-1:0] d_q [1:M];
	logic          neg_q [1:M];
	logic [TW-1:0] t_q [1:M];
	logic [M-1:0]  n_in;
	logic [DW-1:0] d_in;
	logic          neg_in;

	// magnitudes and result sign
	always_comb begin
		n_in = num[NW-1] ? M'(-num) : M'(num);
		d_in = den[DW-1] ? DW'(-den) : DW'(den);
		neg_in = num[NW-1] ^ den[DW-1];
	end

	for (genvar i = 0; i < M; i++) begin : g_st
		logic [M-1:0]  n_cur;
		logic [DW-1:0] r_cur;
		logic [M-1:0]  q_cur;
		logic [DW-1:0] d_cur;
		logic          neg_cur;
		logic [TW-1:0] t_cur;
		logic [DW:0]   shl;
		logic [DW:0]   trial;

		if (i == 0) begin : g_in
			assign n_cur = n_in;
			assign r_cur = '0;
			assign q_cur = '0;
			assign d_cur = d_in;
			assign neg_cur = neg_in;
			assign t_cur = tag_in;
		end else begin : g_mid
			assign n_cur = n_q[i];
			assign r_cur = r_q[i];
			assign q_cur = q_q[i];
			assign d_cur = d_q[i];
			assign neg_cur = neg_q[i];
			assign t_cur = t_q[i];
		end

		always_comb begin
			shl = {r_cur, n_cur[M-1-i]};
			trial = shl - {1'b0, d_cur};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d_q[i+1] <= d_cur;
				neg_q[i+1] <= neg_cur;
				t_q[i+1] <= t_cur;
				if (!trial[DW]) begin
					q_q[i+1] <= q_cur | (M'(1) << (M-1-i));
				end else begin
					q_q[i+1] <= q_cur;
				end
			end
		end

		// dividend and remainder are not needed past the last stage
		if (i < M - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					n_q[i+1] <= n_cur;
					if (!trial[DW]) begin
						r_q[i+1] <= trial[DW-1:0];
					end else begin
						r_q[i+1] <= shl[DW-1:0];
					end
				end
			end
		end
	end

	assign quo = (d_q[M] == '0) ? '0 : (neg_q[M] ? -$signed(q_q[M]) : $signed(q_q[M]));
	assign tag_out = t_q[M];
endmodule

FILE: sim/triangle_scanline_span_test.sv
// Testbench for triangle_scanline_span: directed and random triangles/scanlines,
// each span checked against an in-bench integer predictor.
// Depends on tss_pkg and the triangle_scanline_span RTL.
module triangle_scanline_span_test;
	timeunit 1ns;
	timeprecision 1ps;
	import tss_pkg::*;

	localparam int CB = COORD_BITS_DEF;
	localparam int LATENCY = 2 * (2 * CB + 1) + 4;
	localparam int WATCHDOG_LIMIT = 20 * LATENCY + 200;

	typedef struct {
		logic            valid;
		logic [OUT_BITS-1:0] xs;
		logic [OUT_BITS-1:0] xe;
	} span_t;

	typedef struct {
		longint x;
		longint y;
	} pt_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [CB-1:0] vertex_a_x = '0, vertex_a_y = '0, vertex_b_x = '0, vertex_b_y = '0;
	logic [CB-1:0] vertex_c_x = '0, vertex_c_y = '0, scan_y = '0;
	logic done, span_valid;
	logic [OUT_BITS-1:0] span_start, span_end;

	span_t expected_spans[$];
	int errors = 0;
	int idle_cycles = 0;

	triangle_scanline_span #(.COORD_BITS(CB)) i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// SV division on longint truncates toward zero
	function automatic longint edge_x(pt_t a, pt_t b, longint y);
		longint den;
		den = b.y - a.y;
		if (den == 0)
			return a.x;
		return a.x + ((y - a.y) * (b.x - a.x)) / den;
	endfunction

	function automatic span_t predict_span(pt_t p1, pt_t p2, pt_t p3, longint y);
		span_t s;
		pt_t t, p4;
		longint xs, xe;
		if (p2.y < p1.y) begin t = p1; p1 = p2; p2 = t; end
		if (p3.y < p2.y) begin t = p2; p2 = p3; p3 = t; end
		if (p2.y < p1.y) begin t = p1; p1 = p2; p2 = t; end
		if (y < p1.y || y > p3.y) begin
			s.valid = 1'b0; s.xs = '0; s.xe = '0;
			return s;
		end
		if (p2.y == p3.y) begin
			xs = edge_x(p1, p2, y);
			xe = edge_x(p1, p3, y);
		end else if (p1.y == p2.y) begin
			xs = edge_x(p1, p3, y);
			xe = edge_x(p2, p3, y);
		end else begin
			p4.x = p1.x + ((p2.y - p1.y) * (p3.x - p1.x)) / (p3.y - p1.y);
			p4.y = p2.y;
			if (y <= p2.y) begin
				xs = edge_x(p1, p2, y);
				xe = edge_x(p1, p4, y);
			end else begin
				xs = edge_x(p2, p3, y);
				xe = edge_x(p4, p3, y);
			end
		end
		s.valid = 1'b1;
		s.xs = xs[OUT_BITS-1:0];
		s.xe = xe[OUT_BITS-1:0];
		return s;
	endfunction

	task automatic send_span(int ax, int ay, int bx, int by, int cx, int cy, int y, int gap);
		pt_t a, b, c;
		repeat (gap) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		vertex_a_x <= CB'(ax); vertex_a_y <= CB'(ay);
		vertex_b_x <= CB'(bx); vertex_b_y <= CB'(by);
		vertex_c_x <= CB'(cx); vertex_c_y <= CB'(cy);
		scan_y <= CB'(y);
		do @(posedge clk); while (busy);
		a.x = ax; a.y = ay; b.x = bx; b.y = by; c.x = cx; c.y = cy;
		expected_spans.push_back(predict_span(a, b, c, y));
	endtask

	task automatic finish_sends();
		start <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		finish_sends();
		wait (expected_spans.size() == 0);
	endtask

	function automatic int rnd_coord();
		case ($urandom_range(0, 3))
			0: return int'($urandom_range(0, 7));
			1: return int'($urandom_range(4088, 4095));
			default: return int'($urandom_range(0, 4095));
		endcase
	endfunction

	task automatic test_directed();
		send_span(0, 0, 0, 0, 0, 0, 0, 0);
		send_span(4095, 4095, 4095, 4095, 4095, 4095, 4095, 0);
		send_span(100, 50, 200, 50, 300, 50, 50, 0);   // all on one row
		send_span(100, 50, 200, 50, 300, 50, 51, 0);   // outside, below
		send_span(100, 10, 0, 100, 400, 100, 55, 1);   // flat bottom
		send_span(0, 10, 400, 10, 200, 300, 200, 0);   // flat top
		send_span(0, 0, 4095, 2000, 100, 4095, 2000, 0); // on split row
		send_span(0, 0, 4095, 2000, 100, 4095, 3000, 2);
		send_span(4095, 0, 0, 1000, 2000, 4095, 500, 0);
		send_span(4095, 4095, 0, 0, 4095, 0, 0, 0);
		send_span(0, 4095, 4095, 0, 0, 0, 4095, 0);
		send_span(10, 500, 20, 600, 30, 700, 499, 0);  // outside, above
		send_span(10, 500, 20, 600, 30, 700, 701, 0);
		send_span(2730, 1365, 1365, 2730, 2730, 2730, 2048, 3);
		send_span(1, 1, 4094, 2, 2, 4094, 3, 0);
		drain();
	endtask

	task automatic test_random();
		int ax, ay, bx, by, cx, cy, y, lo, hi, gap;
		for (int i = 0; i < 450; i++) begin
			ax = rnd_coord(); ay = rnd_coord();
			bx = rnd_coord(); by = rnd_coord();
			cx = rnd_coord(); cy = rnd_coord();
			if ($urandom_range(0, 5) == 0) by = ay;
			if ($urandom_range(0, 5) == 0) cy = by;
			lo = ay < by ? ay : by; lo = lo < cy ? lo : cy;
			hi = ay > by ? ay : by; hi = hi > cy ? hi : cy;
			// mostly rows that hit the triangle
			y = ($urandom_range(0, 4) != 0) ? int'($urandom_range(lo, hi)) : rnd_coord();
			gap = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 7)) : 0;
			if (i >= 150 && i < 250) gap = 0;
			send_span(ax, ay, bx, by, cx, cy, y, gap);
			if (i == 300) drain();
		end
		drain();
	endtask

	always @(posedge clk) begin
		span_t exp_s;
		if (done) begin
			if (expected_spans.size() == 0) begin
				$display("%0t: unexpected span valid=%0d start=%0d end=%0d",
					$time, span_valid, span_start, span_end);
				errors++;
			end else begin
				exp_s = expected_spans.pop_front();
				if (span_valid !== exp_s.valid || span_start !== exp_s.xs ||
					span_end !== exp_s.xe) begin
					$display("%0t: expected valid=%0d start=%0d end=%0d, got valid=%0d start=%0d end=%0d",
						$time, exp_s.valid, exp_s.xs, exp_s.xe,
						span_valid, span_start, span_end);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (done || (start && !busy) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL triangle_scanline_span");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0 && expected_spans.size() == 0)
			$display("PASS triangle_scanline_span");
		else
			$display("FAIL triangle_scanline_span");
		$finish;
	end
endmodule
